[sv/tis_pkg.sv]
`timescale 1ns / 1ps

package tis_pkg;

  localparam int BASE_W = 32;
  localparam int STEP_W = 31;
  localparam int COUNT_W = 6;
  localparam int LEVEL_IDX_W = 6;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_COUNT = 2'd2;

  localparam logic [COUNT_W-1:0] LEVEL_COUNT_RESET = 6'd50;

  localparam logic [1:0] EDGE_01 = 2'd0;
  localparam logic [1:0] EDGE_02 = 2'd1;
  localparam logic [1:0] EDGE_12 = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EDGE,
    S_WAIT,
    S_LEVEL,
    S_FLUSH
  } tis_state_t;

  typedef enum logic [1:0] {
    CU_IDLE,
    CU_DIV,
    CU_MUL
  } cu_state_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } tis_cut_ctl_t;

endpackage

[sv/triangle_isoline_segments.sv]
`timescale 1ns / 1ps

// Takes one triangle word and emits one segment word for every iso level that cuts it, in
// rising level order, with tlast on the final segment; a triangle that no level cuts emits
// nothing. The block is busy for the whole triangle: per level it tests the edges in turn and
// then steps the level, and each cut edge goes through the shared restoring divider and
// interpolation multiplier; it also stalls while the output register waits.

module triangle_isoline_segments #(
  parameter int MAX_LEVELS = 64,
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  // vertex0_x, vertex0_y, vertex0_z, vertex1_x .. vertex1_z, vertex2_x .. vertex2_z,
  // value0, value1, value2
  input  logic [((12*COORD_WIDTH+7)/8)*8-1:0]        s_axis_tdata,
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z, level_index
  output logic [((6*COORD_WIDTH+6+7)/8)*8-1:0]       m_axis_tdata,
  output logic                                       m_axis_tlast,
  input  logic                                       cfg_valid,
  output logic                                       cfg_ready,
  input  logic [tis_pkg::CFG_IDX_W-1:0]              cfg_index,
  input  logic [31:0]                                cfg_data
);
  import tis_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int LW = ((CW > 38) ? CW : 38) + 2;
  localparam int OW = ((6*CW+6+7)/8)*8;
  localparam logic [LEVEL_IDX_W-1:0] TOP_MAX = LEVEL_IDX_W'(MAX_LEVELS - 1);

  tis_state_t state, state_next;

  logic signed [BASE_W-1:0]  level_base;
  logic [STEP_W-1:0]         level_step;
  logic [COUNT_W-1:0]        level_count;

  logic signed [CW-1:0]      pos [3][3];
  logic signed [CW-1:0]      val [3];
  logic signed [LW-1:0]      lv;
  logic [LEVEL_IDX_W-1:0]    lvl;
  logic [LEVEL_IDX_W-1:0]    top;
  logic [1:0]                edge_sel;
  logic [1:0]                cuts;
  logic signed [CW-1:0]      pt0 [3];
  logic signed [CW-1:0]      pt1 [3];
  logic                      pend_valid;
  logic signed [CW-1:0]      pend_s [3];
  logic signed [CW-1:0]      pend_e [3];
  logic [LEVEL_IDX_W-1:0]    pend_lvl;
  logic                      out_valid;
  logic signed [CW-1:0]      out_s [3];
  logic signed [CW-1:0]      out_e [3];
  logic [LEVEL_IDX_W-1:0]    out_lvl;
  logic                      out_last;

  logic [1:0]                ea, eb, lo_i, hi_i;
  logic signed [LW-1:0]      vlo, vhi;
  logic                      is_cut;
  logic [LW-1:0]             num_w, den_w;
  logic                      cu_start;
  tis_cut_ctl_t              cu_ctl;
  logic signed [CW-1:0]      cu_pt [3];
  logic                      in_acc, out_free, seg_move, lvl_last, edge_last;
  logic                      out_load;

  assign cfg_ready = 1'b1;
  assign s_axis_tready = state == S_IDLE;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_base <= '0;
      level_step <= '0;
      level_count <= LEVEL_COUNT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LEVEL_BASE:  level_base <= cfg_data[BASE_W-1:0];
        REG_LEVEL_STEP:  level_step <= cfg_data[STEP_W-1:0];
        REG_LEVEL_COUNT: level_count <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (edge_sel)
      EDGE_01: begin ea = 2'd0; eb = 2'd1; end
      EDGE_02: begin ea = 2'd0; eb = 2'd2; end
      default: begin ea = 2'd1; eb = 2'd2; end
    endcase
    if (val[ea] > val[eb]) begin
      lo_i = eb;
      hi_i = ea;
    end else begin
      lo_i = ea;
      hi_i = eb;
    end
  end

  assign vlo = LW'(val[lo_i]);
  assign vhi = LW'(val[hi_i]);
  assign is_cut = (lv >= vlo) && (lv < vhi);
  assign num_w = lv - vlo;
  assign den_w = vhi - vlo;
  assign edge_last = (edge_sel == EDGE_12) || (edge_sel == EDGE_02 && cuts == 2'd1);
  assign lvl_last = lvl == top;
  assign out_free = !out_valid || m_axis_tready;
  assign seg_move = (state == S_LEVEL) && (cuts != 2'd0) && pend_valid && out_free;
  assign out_load = seg_move || ((state == S_FLUSH) && pend_valid && out_free);
  assign cu_start = (state == S_EDGE) && !(edge_sel == EDGE_12 && cuts == 2'd2) && is_cut;

  tis_cut_unit #(
    .COORD_WIDTH(COORD_WIDTH),
    .FRAC_BITS(FRAC_BITS)
  ) u_cut (
    .clk(clk),
    .rst(rst),
    .start(cu_start),
    .ctl(cu_ctl),
    .num(num_w[CW-1:0]),
    .den(den_w[CW-1:0]),
    .lo(pos[lo_i]),
    .hi(pos[hi_i]),
    .pt(cu_pt)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_acc) state_next = S_EDGE;
      S_EDGE: begin
        if (edge_sel == EDGE_12 && cuts == 2'd2) state_next = S_LEVEL;
        else if (is_cut) state_next = S_WAIT;
        else if (edge_sel == EDGE_12) state_next = S_LEVEL;
      end
      S_WAIT: if (cu_ctl.done) state_next = edge_last ? S_LEVEL : S_EDGE;
      S_LEVEL: begin
        if (cuts == 2'd0 || !pend_valid || out_free)
          state_next = lvl_last ? S_FLUSH : S_EDGE;
      end
      S_FLUSH: if (!pend_valid || out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (m_axis_tready) out_valid <= 1'b0;
      case (state)
        S_IDLE: pend_valid <= 1'b0;
        S_LEVEL: begin
          if (cuts != 2'd0 && (!pend_valid || out_free)) pend_valid <= 1'b1;
        end
        S_FLUSH: begin
          if (pend_valid && out_free) pend_valid <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          for (int v = 0; v < 3; v++) begin
            for (int k = 0; k < 3; k++) pos[v][k] <= s_axis_tdata[(v*3+k)*CW +: CW];
            val[v] <= s_axis_tdata[(9+v)*CW +: CW];
          end
          lv <= LW'(level_base);
          lvl <= '0;
          top <= (level_count > TOP_MAX) ? TOP_MAX : level_count;
          edge_sel <= EDGE_01;
          cuts <= 2'd0;
        end
      end
      S_EDGE: begin
        if (!cu_start && edge_sel != EDGE_12) edge_sel <= edge_sel + 2'd1;
      end
      S_WAIT: begin
        if (cu_ctl.done) begin
          if (cuts == 2'd0) pt0 <= cu_pt;
          else pt1 <= cu_pt;
          cuts <= cuts + 2'd1;
          if (!edge_last) edge_sel <= edge_sel + 2'd1;
        end
      end
      S_LEVEL: begin
        if (cuts == 2'd0 || !pend_valid || out_free) begin
          if (cuts != 2'd0) begin
            pend_s <= pt0;
            pend_e <= (cuts == 2'd1) ? pt0 : pt1;
            pend_lvl <= lvl;
          end
          lv <= lv + LW'({1'b0, level_step});
          lvl <= lvl + 1'b1;
          edge_sel <= EDGE_01;
          cuts <= 2'd0;
        end
        if (seg_move) begin
          out_s <= pend_s;
          out_e <= pend_e;
          out_lvl <= pend_lvl;
          out_last <= 1'b0;
        end
      end
      S_FLUSH: begin
        if (pend_valid && out_free) begin
          out_s <= pend_s;
          out_e <= pend_e;
          out_lvl <= pend_lvl;
          out_last <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast = out_last;
  assign m_axis_tdata = OW'({out_lvl, out_e[2], out_e[1], out_e[0],
                             out_s[2], out_s[1], out_s[0]});

`ifndef SYNTH
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !pend_valid) else $error("segment left pending at idle");
  a_unit_wait: assert property (@(posedge clk) disable iff (rst)
    cu_ctl.busy |-> state == S_WAIT) else $error("cut unit busy outside wait");
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE && state != S_FLUSH) |-> lvl <= top)
    else $error("level index beyond top");
  a_cuts_max: assert property (@(posedge clk) disable iff (rst)
    cu_ctl.done |-> cuts != 2'd2) else $error("third cut on one level");
`endif

endmodule

[sv/tis_cut_unit.sv]
`timescale 1ns / 1ps

module tis_cut_unit #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output tis_pkg::tis_cut_ctl_t         ctl,
  input  logic [COORD_WIDTH-1:0]        num,
  input  logic [COORD_WIDTH-1:0]        den,
  input  logic signed [COORD_WIDTH-1:0] lo [3],
  input  logic signed [COORD_WIDTH-1:0] hi [3],
  output logic signed [COORD_WIDTH-1:0] pt [3]
);
  import tis_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int FB = FRAC_BITS;
  localparam int CNTW = $clog2(FB) + 1;
  localparam int PW = CW + FB + 2;

  cu_state_t state, state_next;

  logic [CW:0]              r;
  logic [CW-1:0]            den_r;
  logic [FB-1:0]            frac;
  logic [CNTW-1:0]          cnt;
  logic signed [CW-1:0]     lo_r [3];
  logic signed [CW-1:0]     hi_r [3];
  logic signed [PW-1:0]     prod;
  logic                     done_r;

  logic [CW+1:0]            r2;
  logic                     take;
  logic [CW+1:0]            r_sub;
  logic [1:0]               mk;
  logic [1:0]               pj;
  logic signed [CW:0]       diff;
  logic signed [FB:0]       fs;
  logic signed [PW-1:0]     pshift;
  logic                     div_last;
  logic                     mul_last;

  assign r2 = {r, 1'b0};
  assign take = r2 >= {2'b00, den_r};
  assign r_sub = r2 - {2'b00, den_r};
  assign mk = cnt[1:0];
  assign pj = cnt[1:0] - 2'd1;
  assign diff = {hi_r[mk][CW-1], hi_r[mk]} - {lo_r[mk][CW-1], lo_r[mk]};
  assign fs = $signed({1'b0, frac});
  assign pshift = prod >>> FB;
  assign div_last = cnt == CNTW'(FB - 1);
  assign mul_last = cnt == CNTW'(3);

  always_comb begin
    state_next = state;
    case (state)
      CU_IDLE: if (start) state_next = CU_DIV;
      CU_DIV:  if (div_last) state_next = CU_MUL;
      CU_MUL:  if (mul_last) state_next = CU_IDLE;
      default: state_next = CU_IDLE;
    endcase
  end

  assign ctl.start = start;
  assign ctl.busy = state != CU_IDLE;
  assign ctl.done = done_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CU_IDLE;
      cnt <= '0;
      done_r <= 1'b0;
    end else begin
      state <= state_next;
      done_r <= (state == CU_MUL) && mul_last;
      case (state)
        CU_IDLE: cnt <= '0;
        CU_DIV:  cnt <= div_last ? '0 : cnt + 1'b1;
        CU_MUL:  cnt <= mul_last ? '0 : cnt + 1'b1;
        default: cnt <= '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      CU_IDLE: begin
        if (start) begin
          r <= {1'b0, num};
          den_r <= den;
          frac <= '0;
          lo_r <= lo;
          hi_r <= hi;
        end
      end
      CU_DIV: begin
        r <= take ? r_sub[CW:0] : r2[CW:0];
        frac <= {frac[FB-2:0], take};
      end
      CU_MUL: begin
        if (!mul_last) prod <= PW'(diff * fs);
        if (cnt != '0) pt[pj] <= lo_r[pj] + pshift[CW-1:0];
      end
      default: ;
    endcase
  end

endmodule
